/* design/crse_pkg.sv */
// Shared constants and command codes of the Catmull-Rom spline evaluator.
package crse_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int MIN_POINTS      = 4;
  localparam int PARAM_W         = 17;
  localparam int CFG_W           = 7;
  localparam int SLOT_W          = 6;
  localparam int QUEUE_DEPTH     = 4;
  localparam int FRAC_W          = 16;

  localparam logic [CFG_W-1:0]   COUNT_RESET = 7'd4;
  localparam logic [PARAM_W-1:0] U_ONE       = 17'h10000;
  localparam int                 RND_HALF    = 32768;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

endpackage

/* design/catmull_rom_spline_eval.sv */
// Top level of the uniform Catmull-Rom spline evaluator.
//
// Channels:
//   in_*   : items. cmd write stores one 3D control point in slot point_index;
//            cmd eval evaluates the curve at curve_param (Q1.16).
//   out_*  : one result item (pos_x/y/z, Q16.16, saturated) per eval item,
//            none per write. Results leave in item order.
//   cfg_*  : point_count write port, always ready; write only while idle.
// Throughput: one item per cycle unless a held result is stalled, set by
//   the front (one multiply for the segment) and the nine-stage evaluator,
//   three Horner multiplies per lane.
// A write followed directly by an eval reading that slot sees the new point.
// Reset: point_count returns to 4, queue and pipeline empty. Point stores
//   are not cleared; reading a slot never written gives undefined coordinates.
// Stall: a stalled result holds out_*; the evaluator freezes, the 4-entry
//   queue keeps filling and in_stall rises once it is full.
module catmull_rom_spline_eval import crse_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_cmd,
  input  logic [SLOT_W-1:0]      in_point_index,
  input  logic [COORD_WIDTH-1:0] in_point_x,
  input  logic [COORD_WIDTH-1:0] in_point_y,
  input  logic [COORD_WIDTH-1:0] in_point_z,
  input  logic [PARAM_W-1:0]     in_curve_param,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_WIDTH-1:0] out_pos_x,
  output logic [COORD_WIDTH-1:0] out_pos_y,
  output logic [COORD_WIDTH-1:0] out_pos_z
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int ENT_W = 2 + 4 * IDX_W + PARAM_W + 3 * COORD_WIDTH;

  logic [ENT_W-1:0] ent_in, ent_head;
  logic             q_full, q_valid, q_pop, push;

  // an item enters the queue the edge it is accepted
  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;

  crse_front #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_cmd         (in_cmd),
    .in_point_index (in_point_index),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .in_curve_param (in_curve_param),
    .ent            (ent_in)
  );

  crse_fifo #(
    .W (ENT_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (ent_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (ent_head)
  );

  crse_back #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (q_valid),
    .ent       (ent_head),
    .ent_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_pos_z (out_pos_z)
  );

endmodule

/* design/crse_fifo.sv */
// Small queue between the classifying front and the evaluating back.
module crse_fifo import crse_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [W-1:0]     mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/crse_front.sv */
// Front end: count register, segment selection, neighbour indices, item packing.
module crse_front import crse_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int ENT_W = 2 + 4 * IDX_W + PARAM_W + 3 * COORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_cmd,
  input  logic [SLOT_W-1:0]      in_point_index,
  input  logic [COORD_WIDTH-1:0] in_point_x,
  input  logic [COORD_WIDTH-1:0] in_point_y,
  input  logic [COORD_WIDTH-1:0] in_point_z,
  input  logic [PARAM_W-1:0]     in_curve_param,
  output logic [ENT_W-1:0]       ent
);

  localparam int CNT_W = IDX_W + 1;
  localparam int TD_W  = PARAM_W + IDX_W;

  logic [CFG_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   n, dm1, seg_raw, seg, s3;
  logic [IDX_W-1:0]   d, i0, i1, i2, i3, waddr, a1;
  logic [TD_W-1:0]    td, ul_full;
  logic [PARAM_W-1:0] u;
  logic               wen;

  assign cfg_ready = 1'b1;
  assign count_nxt = (cfg_valid && cfg_ready) ? cfg_data : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else begin
      count_r <= count_nxt;
    end
  end

  // saturate the point count to MIN_POINTS..MAX_POINTS
  always_comb begin
    if (int'(count_r) < MIN_POINTS) begin
      n = CNT_W'(MIN_POINTS);
    end else if (int'(count_r) > MAX_POINTS) begin
      n = CNT_W'(MAX_POINTS);
    end else begin
      n = CNT_W'(count_r);
    end
  end

  assign d   = IDX_W'(n - CNT_W'(1));
  assign dm1 = n - CNT_W'(2);
  assign td  = TD_W'(in_curve_param) * TD_W'(d);
  assign seg_raw = td[TD_W-1:FRAC_W];
  assign seg     = (seg_raw > dm1) ? dm1 : seg_raw;
  assign ul_full = td - {seg, FRAC_W'(0)};
  assign u       = (ul_full > TD_W'(U_ONE)) ? U_ONE : ul_full[PARAM_W-1:0];

  // neighbours, end points repeated
  assign s3 = seg + CNT_W'(2);
  assign i1 = seg[IDX_W-1:0];
  assign i0 = (seg == '0) ? '0 : IDX_W'(seg - CNT_W'(1));
  assign i2 = IDX_W'(seg + CNT_W'(1));
  assign i3 = (s3 >= n) ? i2 : s3[IDX_W-1:0];

  assign wen   = (int'(in_point_index) < MAX_POINTS);
  assign waddr = IDX_W'(in_point_index);
  assign a1    = (in_cmd == CMD_EVAL) ? i1 : waddr;

  assign ent = {in_cmd, wen, i0, a1, i2, i3, u, in_point_x, in_point_y, in_point_z};

endmodule

/* design/crse_back.sv */
// Back end: point stores, Catmull-Rom Horner pipeline per coordinate, output register.
module crse_back import crse_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int ENT_W = 2 + 4 * IDX_W + PARAM_W + 3 * COORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   ent_valid,
  input  logic [ENT_W-1:0]       ent,
  output logic                   ent_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_WIDTH-1:0] out_pos_x,
  output logic [COORD_WIDTH-1:0] out_pos_y,
  output logic [COORD_WIDTH-1:0] out_pos_z
);

  localparam int CW  = COORD_WIDTH;
  localparam int A_W = CW + 6;
  localparam int P_W = A_W + PARAM_W + 1;
  localparam logic signed [A_W-1:0] SMAX = {{(A_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [A_W-1:0] SMIN = {{(A_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic               e_cmd, e_wen;
  logic [IDX_W-1:0]   a0, a1, a2, a3;
  logic [PARAM_W-1:0] e_u;
  logic [CW-1:0]      e_x, e_y, e_z;
  logic               en, wr;
  logic [IDX_W-1:0]   addr [4];
  logic [3*CW-1:0]    rd [4];
  logic [CW-1:0]      pos [3];

  logic [8:1]         v_r;
  logic               out_valid_r;
  logic [PARAM_W-1:0] u_r [1:6];

  assign {e_cmd, e_wen, a0, a1, a2, a3, e_u, e_x, e_y, e_z} = ent;
  assign addr[0] = a0;
  assign addr[1] = a1;
  assign addr[2] = a2;
  assign addr[3] = a3;

  // whole pipeline moves together unless the held result is stalled
  assign en      = !out_valid_r || !out_stall;
  assign ent_pop = ent_valid && en;
  assign wr      = ent_pop && (e_cmd == CMD_WRITE) && e_wen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[7:1], ent_pop && (e_cmd == CMD_EVAL)};
      out_valid_r <= v_r[8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[1] <= e_u;
      for (int s = 2; s <= 6; s++) begin
        u_r[s] <= u_r[s-1];
      end
    end
  end

  // four copies of the store, one per neighbour read port
  for (genvar k = 0; k < 4; k++) begin : g_store
    logic [3*CW-1:0] mem [MAX_POINTS];
    logic [3*CW-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (wr) begin
        mem[a1] <= {e_x, e_y, e_z};
      end
      if (en) begin
        rd_r <= mem[addr[k]];
      end
    end

    assign rd[k] = rd_r;
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic signed [A_W-1:0] q0, q1, q2, q3;
    logic signed [A_W-1:0] e3_r, e2_r, e1_r, e0_r;
    logic signed [P_W-1:0] prod1_r, prod2_r, prod3_r;
    logic signed [A_W-1:0] e2b_r, e1b_r, e0b_r;
    logic signed [A_W-1:0] acc1_r, e1c_r, e0c_r;
    logic signed [A_W-1:0] e1d_r, e0d_r;
    logic signed [A_W-1:0] acc2_r, e0e_r;
    logic signed [A_W-1:0] e0f_r, acc3_r;
    logic signed [P_W-1:0] r1, r2, r3;
    logic signed [A_W-1:0] half;
    logic [CW-1:0]         pos_r;

    assign q0 = A_W'($signed(rd[0][(2-c)*CW +: CW]));
    assign q1 = A_W'($signed(rd[1][(2-c)*CW +: CW]));
    assign q2 = A_W'($signed(rd[2][(2-c)*CW +: CW]));
    assign q3 = A_W'($signed(rd[3][(2-c)*CW +: CW]));

    // round half up: (p + 2^15) >> 16
    assign r1   = prod1_r + P_W'(RND_HALF);
    assign r2   = prod2_r + P_W'(RND_HALF);
    assign r3   = prod3_r + P_W'(RND_HALF);
    assign half = (acc3_r + A_W'(1)) >>> 1;

    always_ff @(posedge clk) begin
      if (en) begin
        e3_r    <= -q0 + A_W'(3) * q1 - A_W'(3) * q2 + q3;
        e2_r    <= A_W'(2) * q0 - A_W'(5) * q1 + A_W'(4) * q2 - q3;
        e1_r    <= q2 - q0;
        e0_r    <= A_W'(2) * q1;
        prod1_r <= P_W'(e3_r) * P_W'($signed({1'b0, u_r[2]}));
        e2b_r   <= e2_r;
        e1b_r   <= e1_r;
        e0b_r   <= e0_r;
        acc1_r  <= A_W'(r1 >>> FRAC_W) + e2b_r;
        e1c_r   <= e1b_r;
        e0c_r   <= e0b_r;
        prod2_r <= P_W'(acc1_r) * P_W'($signed({1'b0, u_r[4]}));
        e1d_r   <= e1c_r;
        e0d_r   <= e0c_r;
        acc2_r  <= A_W'(r2 >>> FRAC_W) + e1d_r;
        e0e_r   <= e0d_r;
        prod3_r <= P_W'(acc2_r) * P_W'($signed({1'b0, u_r[6]}));
        e0f_r   <= e0e_r;
        acc3_r  <= A_W'(r3 >>> FRAC_W) + e0f_r;
        if (half > SMAX) begin
          pos_r <= SMAX[CW-1:0];
        end else if (half < SMIN) begin
          pos_r <= SMIN[CW-1:0];
        end else begin
          pos_r <= half[CW-1:0];
        end
      end
    end

    assign pos[c] = pos_r;
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = pos[0];
  assign out_pos_y = pos[1];
  assign out_pos_z = pos[2];

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the Catmull-Rom spline evaluator.
module testbench;
  import crse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 64;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic              cmd;
    logic [5:0]        slot;
    logic [31:0]       px;
    logic [31:0]       py;
    logic [31:0]       pz;
    logic [16:0]       t;
  } spl_item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } spl_pos_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = COUNT_RESET;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = CMD_WRITE;
  logic [SLOT_W-1:0] in_point_index = '0;
  logic [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic [PARAM_W-1:0] in_curve_param = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_pos_x, out_pos_y, out_pos_z;

  always #5 clk = ~clk;

  catmull_rom_spline_eval DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_point_index(in_point_index), .in_point_x(in_point_x),
    .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_curve_param(in_curve_param),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z)
  );

  // predictor state: its own copy of the point store and the count
  logic signed [31:0] pts_x [NPTS];
  logic signed [31:0] pts_y [NPTS];
  logic signed [31:0] pts_z [NPTS];
  bit written [NPTS];
  int pcount = 4;

  spl_item_t pending_items[$];
  spl_pos_t  expected_pos[$];
  int mismatches = 0, checked = 0, queries = 0, watchdog_cnt = 0;
  bit driver_on = 1'b0;
  int burst_left = 0, gap_left = 0;
  int stall_mode = 0;

  // round-half-up of a*u/2^16, u in 0..65536 (floor shift on signed 64 bit)
  function automatic longint mul_rnd(longint a, longint u);
    return (a * u + 32768) >>> 16;
  endfunction

  function automatic logic [31:0] horner(longint p0, longint p1, longint p2,
                                         longint p3, longint u);
    longint e3, e2, e1, e0, acc, r;
    e3 = -p0 + 3*p1 - 3*p2 + p3;
    e2 = 2*p0 - 5*p1 + 4*p2 - p3;
    e1 = p2 - p0;
    e0 = 2*p1;
    acc = mul_rnd(e3, u) + e2;
    acc = mul_rnd(acc, u) + e1;
    acc = mul_rnd(acc, u) + e0;
    r = (acc + 1) >>> 1;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // apply one accepted item to the predictor; queue a position for a query
  function automatic void predict_item(spl_item_t it);
    longint n, d, td, sg, ul;
    int i0, i1, i2, i3;
    spl_pos_t p;
    if (it.cmd == CMD_WRITE) begin
      pts_x[it.slot] = it.px;
      pts_y[it.slot] = it.py;
      pts_z[it.slot] = it.pz;
      return;
    end
    n = pcount < 4 ? 4 : (pcount > NPTS ? NPTS : pcount);
    d = n - 1;
    td = longint'(it.t) * d;
    sg = td >>> 16;
    if (sg > d - 1) sg = d - 1;
    ul = td - sg * 65536;
    if (ul > 65536) ul = 65536;
    i1 = int'(sg);
    i0 = (i1 == 0) ? 0 : i1 - 1;
    i2 = i1 + 1;
    i3 = i1 + 2;
    if (i3 >= n) i3 = i2;
    p.x = horner(pts_x[i0], pts_x[i1], pts_x[i2], pts_x[i3], ul);
    p.y = horner(pts_y[i0], pts_y[i1], pts_y[i2], pts_y[i3], ul);
    p.z = horner(pts_z[i0], pts_z[i1], pts_z[i2], pts_z[i3], ul);
    expected_pos.push_back(p);
    queries++;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 255) << 16;
      3: return -($urandom_range(0, 255) << 16);
      default: return $urandom();
    endcase
  endfunction

  // item builders; queries only ever touch written slots
  function automatic void add_write(int slot, logic [31:0] x, logic [31:0] y,
                                    logic [31:0] z);
    spl_item_t it;
    it.cmd = CMD_WRITE; it.slot = slot[5:0];
    it.px = x; it.py = y; it.pz = z;
    it.t = 17'($urandom());
    written[slot] = 1'b1;
    pending_items.push_back(it);
  endfunction

  function automatic void add_query(logic [16:0] t);
    spl_item_t it;
    it.cmd = CMD_EVAL; it.slot = 6'($urandom());
    it.px = $urandom(); it.py = $urandom(); it.pz = $urandom();
    it.t = t;
    pending_items.push_back(it);
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return U_ONE;
      2: return 17'h1FFFF;
      3: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // driver: bursts and gaps; payload held while stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_item(pending_items.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (driver_on && pending_items.size() > 0 &&
                     !(in_valid && !in_stall && pending_items.size() == 0)) begin
          in_valid       <= 1'b1;
          in_cmd         <= pending_items[0].cmd;
          in_point_index <= pending_items[0].slot;
          in_point_x     <= pending_items[0].px;
          in_point_y     <= pending_items[0].py;
          in_point_z     <= pending_items[0].pz;
          in_curve_param <= pending_items[0].t;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern changes mode every so often
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // monitor: compare each result item against the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) watchdog_cnt <= 0;
      else watchdog_cnt <= watchdog_cnt + 1;
      if (out_valid && !out_stall) begin
        if (expected_pos.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h %h %h",
                                         out_pos_x, out_pos_y, out_pos_z);
        end else begin
          spl_pos_t e;
          e = expected_pos.pop_front();
          checked++;
          if (e.x !== out_pos_x || e.y !== out_pos_y || e.z !== out_pos_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %h %h %h, got %h %h %h", checked,
                       e.x, e.y, e.z, out_pos_x, out_pos_y, out_pos_z);
          end
        end
      end
      if (watchdog_cnt >= WATCHDOG) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic drain();
    driver_on = 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk);
    wait (!in_valid && expected_pos.size() == 0);
    repeat (20) @(posedge clk);
    driver_on = 1'b0;
  endtask

  task automatic set_count(int c);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= c[6:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pcount = c;
  endtask

  // load count points with random content, then random queries and rewrites
  task automatic run_phase(int c, int nq);
    for (int i = 0; i < c; i++) add_write(i, rand_coord(), rand_coord(), rand_coord());
    for (int k = 0; k < nq; k++) begin
      if ($urandom_range(0, 5) == 0)
        add_write($urandom_range(0, c - 1), rand_coord(), rand_coord(), rand_coord());
      else add_query(rand_param());
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // directed: reset count, extremes of coordinates and parameter
    add_write(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    add_write(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    add_write(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_write(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000);
    add_query(17'd0);
    add_query(17'd21845);
    add_query(17'd32768);
    add_query(U_ONE);
    add_query(17'h1FFFF);
    add_write(63, 32'h1234_5678, 32'h0, 32'hFFFF_0000);
    add_query(17'd1);
    add_query(17'd65535);
    drain();
    // count register: below range saturates to 4, then the top extreme
    set_count(0);
    add_query(U_ONE); add_query(17'd40000);
    drain();
    set_count(64);
    for (int i = 0; i < 64; i++) add_write(i, rand_coord(), rand_coord(), rand_coord());
    add_query(17'd0); add_query(17'd1040); add_query(U_ONE); add_query(17'h1FFFF);
    drain();
    set_count(127);  // saturates to 64, all slots written already
    add_query(17'd65000); add_query(17'd300);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      int c;
      c = (ph == 0) ? 4 : (ph == 1) ? 64 : $urandom_range(4, 64);
      set_count(c);
      run_phase(c, 60);
    end
    $display("covered %0d result items from %0d queries over several point counts",
             checked, queries);
    if (mismatches == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule

/* catmull_rom_spline_eval.f */
design/crse_pkg.sv
design/crse_fifo.sv
design/crse_front.sv
design/crse_back.sv
design/catmull_rom_spline_eval.sv
dv/testbench.sv
